[sv/rlcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcf_pkg - shared types and constants of the RGB linear color fader
// Beat structs for both channels, field widths, command codes and the
// control/status bundle between the top level and the mixing unit.
// ----------------------------------------------------------------------------
package rlcf_pkg;

   localparam int COLOR_W = 24;
   localparam int CHAN_W  = 8;
   localparam int STEP_W  = 16;
   localparam int IVAL_W  = 8;
   localparam int TICK_W  = 9;
   localparam int CNT_W   = 3;
   localparam int SEL_W   = 2;

   localparam logic [TICK_W-1:0] TICK_MAX  = 9'd256;
   localparam logic [SEL_W-1:0]  LAST_CHAN = 2'd2;

   // command codes of the func field
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   typedef struct packed {
      logic                func;
      logic [COLOR_W-1:0]  target_color;
      logic [STEP_W-1:0]   fade_steps;
      logic [IVAL_W-1:0]   step_interval;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              fade_done;
   } rsp_type;

   typedef struct packed {
      logic start;
   } mix_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mix_sts_type;

endpackage

[sv/rgb_linear_color_fader.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_linear_color_fader - linear RGB fade interpolator
// Takes start-fade commands and millisecond ticks; on a tick that is due,
// emits one interpolated color and advances the fade.
//
//   channel | ports                        | beat
//   --------+------------------------------+-------------------------------
//   request | req_valid req_ready req_data | func, target, steps, interval
//   result  | rsp_valid rsp_ready rsp_data | red, green, blue, fade_done
//
// A start command or a tick that emits nothing is done on acceptance. A tick
// that emits a color is accepted, then runs through the shared bit-serial
// multiply/divide unit (multiply, then 8 quotient bits) for each of the three
// channels; the fader then sees the unit's done flag and hands the color to
// the result register.
// Reset clears the start and goal colors, the fade state and the tick counter to zero.
// A stalled result holds in its register; the next request is accepted
// meanwhile, and a later color waits until that register frees.
// ----------------------------------------------------------------------------
module rgb_linear_color_fader (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rlcf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rlcf_pkg::rsp_type rsp_data
);
   import rlcf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MIX  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [COLOR_W-1:0] start_color_ff, start_color_in;
   logic [COLOR_W-1:0] goal_color_ff, goal_color_in;
   logic [STEP_W-1:0]  step_total_ff, step_total_in;
   logic [STEP_W-1:0]  step_index_ff, step_index_in;
   logic [IVAL_W-1:0]  interval_ff, interval_in;
   logic [TICK_W-1:0]  ticks_ff, ticks_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_beat;
   logic               rsp_free;
   logic [TICK_W-1:0]  ticks_inc;
   logic [STEP_W-1:0]  index_next;
   mix_ctl_type        mix_ctl;
   mix_sts_type        mix_sts;
   logic [COLOR_W-1:0] mix_color;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_beat   = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign ticks_inc  = (ticks_ff < TICK_MAX) ? ticks_ff + 1'b1 : ticks_ff;
   assign index_next = step_index_ff + 1'b1;

   rlcf_mix_unit u_mix (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mix_ctl),
      .start_color (start_color_ff),
      .goal_color  (goal_color_ff),
      .total       (step_total_ff),
      .index       (step_index_ff),
      .sts         (mix_sts),
      .color       (mix_color)
   );

   // fade control
   always_comb begin
      state_in       = state_ff;
      start_color_in = start_color_ff;
      goal_color_in  = goal_color_ff;
      step_total_in  = step_total_ff;
      step_index_in  = step_index_ff;
      interval_in    = interval_ff;
      ticks_in       = ticks_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      mix_ctl.start  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_data.func == FUNC_START) begin
                  goal_color_in = req_data.target_color;
                  step_total_in = req_data.fade_steps;
                  interval_in   = req_data.step_interval;
                  step_index_in = '0;
               end else if ((step_index_ff < step_total_ff) &&
                            (ticks_inc > TICK_W'(interval_ff))) begin
                  ticks_in      = '0;
                  mix_ctl.start = 1'b1;
                  state_in      = ST_MIX;
               end else begin
                  ticks_in = ticks_inc;
               end
            end
         end
         ST_MIX: begin
            if (mix_sts.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hand the color over once the result register frees
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.red       = mix_color[23:16];
               rsp_data_in.green     = mix_color[15:8];
               rsp_data_in.blue      = mix_color[7:0];
               rsp_data_in.fade_done = (index_next == step_total_ff);
               step_index_in         = index_next;
               if (index_next == step_total_ff) begin
                  start_color_in = goal_color_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_color_ff <= '0;
         goal_color_ff  <= '0;
         step_total_ff  <= '0;
         step_index_ff  <= '0;
         interval_ff    <= '0;
         ticks_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         start_color_ff <= start_color_in;
         goal_color_ff  <= goal_color_in;
         step_total_ff  <= step_total_in;
         step_index_ff  <= step_index_in;
         interval_ff    <= interval_in;
         ticks_ff       <= ticks_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the step index never runs past the step count
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      step_index_ff <= step_total_ff)
      else $error("step index beyond step count");

   // a new result beat only comes from the finish state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside finish state");

   // the mixing unit only completes while the fader waits on it
   a_mix_done: assert property (@(posedge clock) disable iff (reset)
      mix_sts.done |-> (state_ff == ST_MIX))
      else $error("mix unit done while not awaited");

   // the mixing unit rests whenever the fader takes requests
   a_mix_rest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mix_sts.busy)
      else $error("mix unit busy while fader idle");

   // the counter stays within its saturation bound
   a_tick_bound: assert property (@(posedge clock) disable iff (reset)
      ticks_ff <= TICK_MAX)
      else $error("tick counter beyond saturation");

endmodule

[sv/rlcf_mix_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcf_mix_unit - bit-serial color interpolator
// For each of red, green and blue in turn: builds
// start*(total-index) + goal*index one bit of the channel bytes per cycle,
// then divides by total one quotient bit per cycle.
// Quotient bits shift into a 24-bit result register, red first.
// ----------------------------------------------------------------------------
module rlcf_mix_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  rlcf_pkg::mix_ctl_type        ctl,
   input  logic [rlcf_pkg::COLOR_W-1:0] start_color,
   input  logic [rlcf_pkg::COLOR_W-1:0] goal_color,
   input  logic [rlcf_pkg::STEP_W-1:0]  total,
   input  logic [rlcf_pkg::STEP_W-1:0]  index,
   output rlcf_pkg::mix_sts_type        sts,
   output logic [rlcf_pkg::COLOR_W-1:0] color
);
   import rlcf_pkg::*;

   typedef enum logic [2:0] {
      M_IDLE = 3'b001,
      M_MUL  = 3'b010,
      M_DIV  = 3'b100
   } mix_state_type;

   mix_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SEL_W-1:0]   chan_ff, chan_in;
   logic               done_ff, done_in;

   logic [COLOR_W-1:0] sa_ff, sa_in;
   logic [COLOR_W-1:0] sb_ff, sb_in;
   logic [COLOR_W-1:0] acc_ff, acc_in;
   logic [COLOR_W-1:0] dvs_ff, dvs_in;
   logic [COLOR_W-1:0] res_ff, res_in;
   logic [STEP_W-1:0]  diff_ff, diff_in;
   logic [STEP_W-1:0]  tot_ff, tot_in;
   logic [STEP_W-1:0]  idx_ff, idx_in;

   logic [STEP_W-1:0]  addend;
   logic [COLOR_W-1:0] acc_shl;
   logic               fits;
   logic               last_bit;

   assign last_bit = (cnt_ff == CNT_W'(CHAN_W - 1));
   assign acc_shl  = {acc_ff[COLOR_W-2:0], 1'b0};
   assign fits     = (acc_ff >= dvs_ff);

   // pick the partial product from the top bits of both channel bytes
   always_comb begin
      case ({sa_ff[COLOR_W-1], sb_ff[COLOR_W-1]})
         2'b10:   addend = diff_ff;
         2'b01:   addend = idx_ff;
         2'b11:   addend = tot_ff;
         default: addend = '0;
      endcase
   end

   // sequencer and datapath
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      chan_in  = chan_ff;
      done_in  = 1'b0;
      sa_in    = sa_ff;
      sb_in    = sb_ff;
      acc_in   = acc_ff;
      dvs_in   = dvs_ff;
      res_in   = res_ff;
      diff_in  = diff_ff;
      tot_in   = tot_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         M_IDLE: begin
            if (ctl.start) begin
               sa_in    = start_color;
               sb_in    = goal_color;
               tot_in   = total;
               idx_in   = index;
               diff_in  = total - index;
               acc_in   = '0;
               cnt_in   = '0;
               chan_in  = '0;
               state_in = M_MUL;
            end
         end
         M_MUL: begin
            // advance one bit of each channel byte
            acc_in = acc_shl + COLOR_W'(addend);
            sa_in  = {sa_ff[COLOR_W-2:0], 1'b0};
            sb_in  = {sb_ff[COLOR_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (last_bit) begin
               dvs_in   = {1'b0, tot_ff, {(CHAN_W-1){1'b0}}};
               state_in = M_DIV;
            end
         end
         M_DIV: begin
            // restoring division, one quotient bit per cycle
            if (fits) begin
               acc_in = acc_ff - dvs_ff;
            end
            res_in = {res_ff[COLOR_W-2:0], fits};
            dvs_in = {1'b0, dvs_ff[COLOR_W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (last_bit) begin
               acc_in = '0;
               if (chan_ff == LAST_CHAN) begin
                  done_in  = 1'b1;
                  state_in = M_IDLE;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = M_MUL;
               end
            end
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         cnt_ff   <= '0;
         chan_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         chan_ff  <= chan_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff   <= sa_in;
      sb_ff   <= sb_in;
      acc_ff  <= acc_in;
      dvs_ff  <= dvs_in;
      res_ff  <= res_in;
      diff_ff <= diff_in;
      tot_ff  <= tot_in;
      idx_ff  <= idx_in;
   end

   assign sts.busy = (state_ff != M_IDLE);
   assign sts.done = done_ff;
   assign color    = res_ff;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench of the RGB linear color fader
// Drives start-fade and tick beats through the request channel with random
// gaps and result back-pressure. A scoreboard class keeps its own fade state,
// works out the color each accepted tick emits, and compares every result
// beat field by field against the oldest expected color.
// ----------------------------------------------------------------------------
module tb_top;
   import rlcf_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_SHOWN    = 50;
   localparam int RANDOM_BEATS = 1000;
   localparam int CALM_BEATS   = 880;

   // Fade state mirror, expected colors and the comparison of result beats
   class fade_scoreboard;
      logic [COLOR_W-1:0] base_color = '0;
      logic [COLOR_W-1:0] goal_color = '0;
      logic [STEP_W-1:0]  step_total = '0;
      logic [STEP_W-1:0]  step_index = '0;
      logic [IVAL_W-1:0]  gap_ticks  = '0;
      logic [TICK_W-1:0]  tick_count = '0;
      rsp_type            color_queue[$];
      int                 emitted = 0;
      int                 errors  = 0;

      task report(string msg);
         if (errors < MAX_SHOWN) $display("mismatch: %s", msg);
         errors++;
      endtask

      // weighted mix of one channel at the current step, truncated
      function logic [CHAN_W-1:0] blend(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
         logic [31:0] num;
         num = 32'(a) * (32'(step_total) - 32'(step_index)) + 32'(b) * 32'(step_index);
         return CHAN_W'(num / 32'(step_total));
      endfunction

      // advance the mirror by one accepted request beat
      function void note_request(req_type beat);
         rsp_type want;
         if (beat.func == FUNC_START) begin
            goal_color = beat.target_color;
            step_total = beat.fade_steps;
            gap_ticks  = beat.step_interval;
            step_index = '0;
            return;
         end
         if (tick_count < TICK_MAX) tick_count++;
         if (step_index < step_total && tick_count > {1'b0, gap_ticks}) begin
            tick_count  = '0;
            want.red    = blend(base_color[23:16], goal_color[23:16]);
            want.green  = blend(base_color[15:8], goal_color[15:8]);
            want.blue   = blend(base_color[7:0], goal_color[7:0]);
            step_index++;
            if (step_index == step_total) begin
               base_color     = goal_color;
               want.fade_done = 1'b1;
            end else begin
               want.fade_done = 1'b0;
            end
            color_queue.push_back(want);
            emitted++;
         end
      endfunction

      // compare one result beat with the oldest expected color
      task check_result(rsp_type got);
         rsp_type want;
         if (color_queue.size() == 0) begin
            report($sformatf("color %h with nothing expected", got));
            return;
         end
         want = color_queue.pop_front();
         if (got.red !== want.red)
            report($sformatf("red %h, expected %h", got.red, want.red));
         if (got.green !== want.green)
            report($sformatf("green %h, expected %h", got.green, want.green));
         if (got.blue !== want.blue)
            report($sformatf("blue %h, expected %h", got.blue, want.blue));
         if (got.fade_done !== want.fade_done)
            report($sformatf("fade_done %b, expected %b", got.fade_done, want.fade_done));
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   fade_scoreboard sb = new;

   bit idle_on    = 1'b0;
   bit calm       = 1'b0;
   int beats_sent = 0;
   int stall_left = 0;
   int cycle_count = 0;

   rgb_linear_color_fader uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // hold off the result channel in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 7) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // check result beats before noting this edge's request beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if (req_valid && req_ready) sb.note_request(req_data);
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[rgb_linear_color_fader] ERROR");
         $finish;
      end
   end

   // present one beat, with an optional gap first, and wait for acceptance
   task automatic send_beat(input req_type beat);
      if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_start(input logic [COLOR_W-1:0] color, input logic [STEP_W-1:0] steps,
                             input logic [IVAL_W-1:0] ival);
      req_type beat;
      beat.func          = FUNC_START;
      beat.target_color  = color;
      beat.fade_steps    = steps;
      beat.step_interval = ival;
      send_beat(beat);
   endtask

   // ticks carry random payload in the unused fields
   task automatic send_ticks(input int count);
      req_type beat;
      for (int i = 0; i < count; i++) begin
         beat.func          = FUNC_TICK;
         beat.target_color  = COLOR_W'($urandom);
         beat.fade_steps    = STEP_W'($urandom);
         beat.step_interval = IVAL_W'($urandom);
         send_beat(beat);
      end
   endtask

   initial begin
      int                 seq_no;
      int                 kind;
      int                 span;
      logic [STEP_W-1:0]  steps;
      logic [IVAL_W-1:0]  ival;
      req_type            junk;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: tick with no fade, full-swing fades, zero steps,
      // a step on the tick right after a start, and an interrupted fade
      send_ticks(1);
      send_start(24'hFFFFFF, 16'd1, 8'd0);
      send_ticks(1);
      send_start(24'h000000, 16'd3, 8'd0);
      send_ticks(3);
      send_start(24'h123456, 16'd0, 8'd0);
      send_ticks(2);
      send_start(24'hA5C3E1, 16'd4, 8'd2);
      send_ticks(4);
      send_start(24'hFF00FF, 16'hFFFF, 8'hFF);
      send_ticks(1);
      send_start(24'h00FF00, 16'd2, 8'd1);
      send_ticks(4);

      // random: mostly complete fades, some cut short, some noise,
      // and now and then a long idle run that saturates the tick counter
      seq_no = 0;
      while (beats_sent < RANDOM_BEATS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         calm    = (beats_sent >= CALM_BEATS);
         kind    = $urandom_range(0, 99);
         if (seq_no == 2 || kind < 2) begin
            send_start(COLOR_W'($urandom), 16'd0, IVAL_W'($urandom));
            send_ticks($urandom_range(258, 290));
            send_start(COLOR_W'($urandom), STEP_W'($urandom_range(1, 3)), 8'hFF);
            send_ticks($urandom_range(1, 4));
         end else if (kind < 87) begin
            steps = ($urandom_range(0, 9) == 0) ? STEP_W'($urandom)
                                                 : STEP_W'($urandom_range(1, 8));
            ival  = ($urandom_range(0, 9) == 0) ? IVAL_W'($urandom)
                                                 : IVAL_W'($urandom_range(0, 3));
            span  = int'(steps) * (int'(ival) + 1);
            send_start(COLOR_W'($urandom), steps, ival);
            if (span > 40)
               send_ticks($urandom_range(1, 40));
            else if (kind < 72)
               send_ticks(span + $urandom_range(0, 3));
            else
               send_ticks($urandom_range(0, span));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               junk = {1'($urandom_range(0, 1)), COLOR_W'($urandom),
                       STEP_W'($urandom), IVAL_W'($urandom)};
               send_beat(junk);
            end
         end
         seq_no++;
      end

      // drain outstanding colors, then watch for strays
      req_valid <= 1'b0;
      calm = 1'b1;
      while (sb.color_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("[rgb_linear_color_fader] OK");
      end else begin
         $display("[rgb_linear_color_fader] ERROR");
      end
      $finish;
   end
endmodule
